@@ rtl/core/clt_pkg.sv @@
`timescale 1ns / 1ps

package clt_pkg;

	localparam int unsigned TEMP_W  = 11;
	localparam int unsigned GEAR_W  = 4;
	localparam int unsigned TGT_W   = 6;
	localparam int unsigned RPM_W   = 13;
	localparam int unsigned CHILL_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [GEAR_W-1:0] GEAR_TOP     = 4'd10;
	localparam logic [GEAR_W-1:0] CAP_FROM_TWO = 4'd8;
	localparam logic [GEAR_W-1:0] CAP_FROM_ONE = 4'd6;
	localparam logic [GEAR_W-1:0] FLOOR_ONE    = 4'd5;
	localparam logic [GEAR_W-1:0] FLOOR_TWO    = 4'd7;
	localparam logic [GEAR_W-1:0] FLOOR_THREE  = 4'd9;

	localparam logic [TEMP_W-1:0] FILTER_SEED    = 11'd250;
	localparam logic signed [TEMP_W:0] RESTART_CENTER = 12'sd350;
	localparam logic [TGT_W-1:0]  FIXED_TARGET   = 6'd20;

	localparam logic signed [TEMP_W-1:0] BATT_RISE_TWO_RST = 11'sd350;
	localparam logic signed [TEMP_W-1:0] BATT_RISE_ONE_RST = 11'sd345;
	localparam logic signed [TEMP_W-1:0] BATT_FALL_ONE_RST = 11'sd335;
	localparam logic signed [TEMP_W-1:0] BATT_FALL_TWO_RST = 11'sd330;
	localparam logic [TEMP_W-1:0] CPU_ALARM_ONE_RST   = 11'd650;
	localparam logic [TEMP_W-1:0] CPU_ALARM_TWO_RST   = 11'd750;
	localparam logic [TEMP_W-1:0] CPU_ALARM_THREE_RST = 11'd850;
	localparam logic [TEMP_W-1:0] CPU_ALL_CLEAR_RST   = 11'd550;

	localparam logic MODE_SMART = 1'b0;
	localparam logic MODE_FIXED = 1'b1;

	typedef enum logic {
		OP_TICK,
		OP_RESTART
	} op_t;

	typedef enum logic [1:0] {
		ALARM_CLEAR,
		ALARM_ONE,
		ALARM_TWO,
		ALARM_THREE
	} alarm_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATT_RISE_TWO,
		REG_BATT_RISE_ONE,
		REG_BATT_FALL_ONE,
		REG_BATT_FALL_TWO,
		REG_CPU_ALARM_ONE,
		REG_CPU_ALARM_TWO,
		REG_CPU_ALARM_THREE,
		REG_CPU_ALL_CLEAR
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] batt_rise_two;
		logic signed [TEMP_W-1:0] batt_rise_one;
		logic signed [TEMP_W-1:0] batt_fall_one;
		logic signed [TEMP_W-1:0] batt_fall_two;
		logic [TEMP_W-1:0]        cpu_alarm_one;
		logic [TEMP_W-1:0]        cpu_alarm_two;
		logic [TEMP_W-1:0]        cpu_alarm_three;
		logic [TEMP_W-1:0]        cpu_all_clear;
	} cfg_t;

	typedef struct packed {
		logic [GEAR_W-1:0] base_gear;
		alarm_t            alarm_state;
		logic [TEMP_W-1:0] smoothed_cpu;
		logic              first_sample;
	} state_t;

	typedef struct packed {
		op_t                      opcode;
		logic signed [TEMP_W-1:0] batt_temp;
		logic                     batt_ok;
		logic [TEMP_W-1:0]        cpu_temp;
		logic                     cpu_ok;
	} item_t;

	typedef struct packed {
		logic               run_mode;
		logic [TGT_W-1:0]   target_celsius;
		logic [RPM_W-1:0]   fixed_fan_rpm;
		logic [CHILL_W-1:0] chiller_strength;
		logic [RPM_W-1:0]   fan_rpm_ceiling;
	} lut_t;

	typedef struct packed {
		logic [GEAR_W-1:0] gear;
		lut_t              lut;
		alarm_t            alarm_level;
	} res_t;

	function automatic lut_t gear_lut(input logic [GEAR_W-1:0] g);
		lut_t r;
		r = '0;
		unique case (g)
			4'd0:  r = '{MODE_FIXED, FIXED_TARGET, 13'd2000, 8'd20, 13'd0};
			4'd1:  r = '{MODE_FIXED, FIXED_TARGET, 13'd2200, 8'd40, 13'd0};
			4'd2:  r = '{MODE_FIXED, FIXED_TARGET, 13'd2500, 8'd60, 13'd0};
			4'd3:  r = '{MODE_FIXED, FIXED_TARGET, 13'd2900, 8'd80, 13'd0};
			4'd4:  r = '{MODE_SMART, 6'd18, 13'd0, 8'd0, 13'd3400};
			4'd5:  r = '{MODE_SMART, 6'd16, 13'd0, 8'd0, 13'd4000};
			4'd6:  r = '{MODE_SMART, 6'd15, 13'd0, 8'd0, 13'd4600};
			4'd7:  r = '{MODE_SMART, 6'd14, 13'd0, 8'd0, 13'd5100};
			4'd8:  r = '{MODE_SMART, 6'd13, 13'd0, 8'd0, 13'd5500};
			4'd9:  r = '{MODE_SMART, 6'd12, 13'd0, 8'd0, 13'd5800};
			4'd10: r = '{MODE_FIXED, FIXED_TARGET, 13'd6000, 8'd190, 13'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [GEAR_W-1:0] floor_of(input alarm_t a);
		logic [GEAR_W-1:0] f;
		f = '0;
		unique case (a)
			ALARM_THREE: f = FLOOR_THREE;
			ALARM_TWO:   f = FLOOR_TWO;
			ALARM_ONE:   f = FLOOR_ONE;
			ALARM_CLEAR: f = '0;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/core/clt_step.sv @@
`timescale 1ns / 1ps

module clt_step import clt_pkg::*; #(
	parameter int unsigned HOLD_TICKS = 4,
	parameter int unsigned HOLD_W     = 3
) (
	input  cfg_t              cfg,
	input  state_t            st,
	input  logic [HOLD_W-1:0] hold,
	input  item_t             item,
	output state_t            st_next,
	output logic [HOLD_W-1:0] hold_next,
	output res_t              res
);

	localparam logic [HOLD_W-1:0] HoldLoad = HOLD_W'(HOLD_TICKS);

	logic [TEMP_W+1:0]        filt_sum;
	logic [TEMP_W-1:0]        t;
	alarm_t                   lvl;
	alarm_t                   alarm_n;
	logic                     changed;
	logic [GEAR_W-1:0]        base_c;
	logic [HOLD_W-1:0]        hold_c;
	logic [GEAR_W-1:0]        base_b;
	logic [HOLD_W-1:0]        hold_b;
	logic [GEAR_W-1:0]        floor_g;
	logic [GEAR_W-1:0]        gear;
	logic signed [TEMP_W:0]   rs_diff;
	logic [GEAR_W-1:0]        rs_gear;

	// (25*new + 75*old)/100 is (new + 3*old)/4
	assign filt_sum = {2'b00, item.cpu_temp} + {2'b00, st.smoothed_cpu}
		+ {1'b0, st.smoothed_cpu, 1'b0};
	assign t = st.first_sample ? item.cpu_temp : filt_sum[TEMP_W+1:2];

	always_comb begin
		priority if (t > cfg.cpu_alarm_three) begin
			lvl = ALARM_THREE;
		end else if (t > cfg.cpu_alarm_two) begin
			lvl = ALARM_TWO;
		end else if (t > cfg.cpu_alarm_one) begin
			lvl = ALARM_ONE;
		end else if (t < cfg.cpu_all_clear) begin
			lvl = ALARM_CLEAR;
		end else if (t < cfg.cpu_alarm_one
				&& (st.alarm_state == ALARM_TWO || st.alarm_state == ALARM_THREE)) begin
			lvl = ALARM_ONE;
		end else if (t < cfg.cpu_alarm_two && st.alarm_state == ALARM_THREE) begin
			lvl = ALARM_TWO;
		end else begin
			lvl = st.alarm_state;
		end
	end

	assign changed = item.cpu_ok && (lvl != st.alarm_state);
	assign alarm_n = item.cpu_ok ? lvl : st.alarm_state;
	assign hold_c  = changed ? HoldLoad : hold;

	// cap the base gear when dropping from level two or one to a lower level
	always_comb begin
		base_c = st.base_gear;
		if (changed && st.alarm_state == ALARM_TWO
				&& (lvl == ALARM_CLEAR || lvl == ALARM_ONE) && st.base_gear > CAP_FROM_TWO) begin
			base_c = CAP_FROM_TWO;
		end
		if (changed && st.alarm_state == ALARM_ONE && lvl == ALARM_CLEAR
				&& st.base_gear > CAP_FROM_ONE) begin
			base_c = CAP_FROM_ONE;
		end
	end

	// battery steps, taken only once the hold count is zero; else the hold counts down
	always_comb begin
		base_b = base_c;
		hold_b = hold_c;
		if (hold_c != '0) begin
			hold_b = hold_c - 1'b1;
		end else if (item.batt_ok) begin
			priority if (item.batt_temp >= cfg.batt_rise_two) begin
				base_b = (base_c >= GEAR_TOP - 4'd1) ? GEAR_TOP : base_c + 4'd2;
				hold_b = HoldLoad;
			end else if (item.batt_temp >= cfg.batt_rise_one) begin
				base_b = (base_c >= GEAR_TOP) ? GEAR_TOP : base_c + 4'd1;
				hold_b = HoldLoad;
			end else if (item.batt_temp <= cfg.batt_fall_two) begin
				base_b = (base_c <= 4'd1) ? 4'd0 : base_c - 4'd2;
				hold_b = HoldLoad;
			end else if (item.batt_temp <= cfg.batt_fall_one) begin
				base_b = (base_c == 4'd0) ? 4'd0 : base_c - 4'd1;
				hold_b = HoldLoad;
			end else begin
				base_b = base_c;
			end
		end
	end

	assign floor_g = floor_of(alarm_n);
	assign gear    = (floor_g > base_b) ? floor_g : base_b;

	// restart seed: (batt - 350)/10 toward zero, held to 0..10
	assign rs_diff = {item.batt_temp[TEMP_W-1], item.batt_temp} - RESTART_CENTER;

	always_comb begin
		rs_gear = '0;
		if (item.batt_ok) begin
			for (int k = 1; k <= 10; k++) begin
				if (rs_diff >= (TEMP_W+1)'(10 * k)) begin
					rs_gear = GEAR_W'(k);
				end
			end
		end
	end

	always_comb begin
		if (item.opcode == OP_RESTART) begin
			st_next.base_gear    = rs_gear;
			st_next.alarm_state  = ALARM_CLEAR;
			st_next.smoothed_cpu = FILTER_SEED;
			st_next.first_sample = 1'b1;
			hold_next            = '0;
			res.gear             = rs_gear;
			res.lut              = gear_lut(rs_gear);
			res.alarm_level      = ALARM_CLEAR;
		end else begin
			st_next.base_gear    = base_b;
			st_next.alarm_state  = alarm_n;
			st_next.smoothed_cpu = item.cpu_ok ? t : st.smoothed_cpu;
			st_next.first_sample = st.first_sample && !item.cpu_ok;
			hold_next            = hold_b;
			res.gear             = gear;
			res.lut              = gear_lut(gear);
			res.alarm_level      = alarm_n;
		end
	end

endmodule

@@ rtl/core/cooler_level_thermal_controller.sv @@
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | opcode batt_temp batt_ok cpu_temp cpu_ok
// out      | out_valid / out_stall| gear run_mode target_celsius fixed_fan_rpm
//          |                      | chiller_strength fan_rpm_ceiling alarm_level
// cfg      | cfg_we               | cfg_index cfg_data
//
// one beat per cycle while the output is not stalled; a taken beat passes through
// the input register, then the step logic into the result register
// the controller state updates in the same edge that loads the result register
// arst_n sets state, thresholds and valid flags to their reset values
// a stalled output holds; the input register still takes one beat meanwhile

module cooler_level_thermal_controller import clt_pkg::*; #(
	parameter int unsigned HOLD_TICKS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic signed [TEMP_W-1:0] batt_temp,
	input  logic                     batt_ok,
	input  logic [TEMP_W-1:0]        cpu_temp,
	input  logic                     cpu_ok,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [GEAR_W-1:0]        gear,
	output logic                     run_mode,
	output logic [TGT_W-1:0]         target_celsius,
	output logic [RPM_W-1:0]         fixed_fan_rpm,
	output logic [CHILL_W-1:0]       chiller_strength,
	output logic [RPM_W-1:0]         fan_rpm_ceiling,
	output logic [1:0]               alarm_level,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [TEMP_W-1:0]        cfg_data
);

	localparam int unsigned HoldW = $clog2(HOLD_TICKS + 1);

	cfg_t              cfg_q;
	state_t            st_q;
	logic [HoldW-1:0]  hold_q;
	item_t             item_s1;
	logic              valid_s1;
	res_t              res_s2;
	logic              valid_s2;

	state_t            st_next;
	logic [HoldW-1:0]  hold_next;
	res_t              res_next;
	logic              advance;
	logic              in_take;
	logic              fire;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.batt_rise_two   <= BATT_RISE_TWO_RST;
			cfg_q.batt_rise_one   <= BATT_RISE_ONE_RST;
			cfg_q.batt_fall_one   <= BATT_FALL_ONE_RST;
			cfg_q.batt_fall_two   <= BATT_FALL_TWO_RST;
			cfg_q.cpu_alarm_one   <= CPU_ALARM_ONE_RST;
			cfg_q.cpu_alarm_two   <= CPU_ALARM_TWO_RST;
			cfg_q.cpu_alarm_three <= CPU_ALARM_THREE_RST;
			cfg_q.cpu_all_clear   <= CPU_ALL_CLEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_BATT_RISE_TWO:   cfg_q.batt_rise_two   <= cfg_data;
				REG_BATT_RISE_ONE:   cfg_q.batt_rise_one   <= cfg_data;
				REG_BATT_FALL_ONE:   cfg_q.batt_fall_one   <= cfg_data;
				REG_BATT_FALL_TWO:   cfg_q.batt_fall_two   <= cfg_data;
				REG_CPU_ALARM_ONE:   cfg_q.cpu_alarm_one   <= cfg_data;
				REG_CPU_ALARM_TWO:   cfg_q.cpu_alarm_two   <= cfg_data;
				REG_CPU_ALARM_THREE: cfg_q.cpu_alarm_three <= cfg_data;
				REG_CPU_ALL_CLEAR:   cfg_q.cpu_all_clear   <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode    <= op_t'(opcode);
			item_s1.batt_temp <= batt_temp;
			item_s1.batt_ok   <= batt_ok;
			item_s1.cpu_temp  <= cpu_temp;
			item_s1.cpu_ok    <= cpu_ok;
		end
	end

	clt_step #(
		.HOLD_TICKS (HOLD_TICKS),
		.HOLD_W     (HoldW)
	) u_step (
		.cfg       (cfg_q),
		.st        (st_q),
		.hold      (hold_q),
		.item      (item_s1),
		.st_next   (st_next),
		.hold_next (hold_next),
		.res       (res_next)
	);

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.base_gear    <= '0;
			st_q.alarm_state  <= ALARM_CLEAR;
			st_q.smoothed_cpu <= FILTER_SEED;
			st_q.first_sample <= 1'b1;
			hold_q            <= '0;
		end else if (fire) begin
			st_q   <= st_next;
			hold_q <= hold_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid        = valid_s2;
	assign gear             = res_s2.gear;
	assign run_mode         = res_s2.lut.run_mode;
	assign target_celsius   = res_s2.lut.target_celsius;
	assign fixed_fan_rpm    = res_s2.lut.fixed_fan_rpm;
	assign chiller_strength = res_s2.lut.chiller_strength;
	assign fan_rpm_ceiling  = res_s2.lut.fan_rpm_ceiling;
	assign alarm_level      = res_s2.alarm_level;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import clt_pkg::*;

	localparam int HOLD_TICKS     = 4;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_TICKS    = 230;
	localparam int GEAR_MAX       = GEAR_TOP;
	localparam int CAP_TWO        = CAP_FROM_TWO;
	localparam int CAP_ONE        = CAP_FROM_ONE;
	localparam int MIN_ONE        = FLOOR_ONE;
	localparam int MIN_TWO        = FLOOR_TWO;
	localparam int MIN_THREE      = FLOOR_THREE;
	localparam int SEED_CPU       = FILTER_SEED;
	localparam int CENTRE_BATT    = RESTART_CENTER;
	localparam int FIXED_TGT      = FIXED_TARGET;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     opcode = 1'b0;
	logic signed [TEMP_W-1:0] batt_temp = '0;
	logic                     batt_ok = 1'b0;
	logic [TEMP_W-1:0]        cpu_temp = '0;
	logic                     cpu_ok = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [GEAR_W-1:0]        gear;
	logic                     run_mode;
	logic [TGT_W-1:0]         target_celsius;
	logic [RPM_W-1:0]         fixed_fan_rpm;
	logic [CHILL_W-1:0]       chiller_strength;
	logic [RPM_W-1:0]         fan_rpm_ceiling;
	logic [1:0]               alarm_level;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [TEMP_W-1:0]        cfg_data = '0;

	cooler_level_thermal_controller #(
		.HOLD_TICKS(HOLD_TICKS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.batt_temp(batt_temp),
		.batt_ok(batt_ok),
		.cpu_temp(cpu_temp),
		.cpu_ok(cpu_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gear(gear),
		.run_mode(run_mode),
		.target_celsius(target_celsius),
		.fixed_fan_rpm(fixed_fan_rpm),
		.chiller_strength(chiller_strength),
		.fan_rpm_ceiling(fan_rpm_ceiling),
		.alarm_level(alarm_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int unsigned rpm_by_gear [11] = '{2000, 2200, 2500, 2900, 3400, 4000, 4600, 5100, 5500,
		5800, 6000};
	bit fixed_by_gear [11] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1};
	int unsigned target_by_gear [11] = '{20, 20, 20, 20, 18, 16, 15, 14, 13, 12, 20};
	int unsigned chill_by_gear [11] = '{20, 40, 60, 80, 0, 0, 0, 0, 0, 0, 190};

	// threshold copies
	int batt_up2 = 350, batt_up1 = 345, batt_dn1 = 335, batt_dn2 = 330;
	int cpu_lvl1 = 650, cpu_lvl2 = 750, cpu_lvl3 = 850, cpu_clear = 550;

	// controller state as predicted
	int     gear_base = 0;
	int     gear_floor = 0;
	int     cpu_filtered = SEED_CPU;
	int     hold_left = 0;
	alarm_t alarm_now = ALARM_CLEAR;
	bit     fresh_filter = 1'b1;

	item_t       ticks_waiting[$];
	res_t        gear_due[$];
	item_t       offered;
	int unsigned beats_taken = 0;
	int unsigned results_seen = 0;
	int unsigned failures = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_off = 0;
	int          cpu_aim = 500;
	logic        calm;

	assign calm = beats_taken >= 700 && beats_taken < 950;

	function automatic res_t gear_result(int g);
		res_t r;
		r = '0;
		r.gear = g[GEAR_W-1:0];
		r.alarm_level = alarm_now;
		if (fixed_by_gear[g]) begin
			r.lut.run_mode = MODE_FIXED;
			r.lut.target_celsius = FIXED_TGT[TGT_W-1:0];
			r.lut.fixed_fan_rpm = rpm_by_gear[g][RPM_W-1:0];
			r.lut.chiller_strength = (chill_by_gear[g] < 1) ? 8'd1 : chill_by_gear[g][CHILL_W-1:0];
			r.lut.fan_rpm_ceiling = '0;
		end else begin
			r.lut.run_mode = MODE_SMART;
			r.lut.target_celsius = target_by_gear[g][TGT_W-1:0];
			r.lut.fixed_fan_rpm = '0;
			r.lut.chiller_strength = '0;
			r.lut.fan_rpm_ceiling = rpm_by_gear[g][RPM_W-1:0];
		end
		return r;
	endfunction

	function automatic res_t step_controller(item_t b);
		int     batt;
		int     cpu;
		int     g;
		int     delta;
		alarm_t lvl;
		batt = int'($signed(b.batt_temp));
		cpu = int'(b.cpu_temp);
		if (b.opcode == OP_RESTART) begin
			g = 0;
			if (b.batt_ok) begin
				g = (batt - CENTRE_BATT) / 10;
				if (g > GEAR_MAX) g = GEAR_MAX;
				if (g < 0) g = 0;
			end
			gear_base = g;
			hold_left = 0;
			alarm_now = ALARM_CLEAR;
			gear_floor = 0;
			cpu_filtered = SEED_CPU;
			fresh_filter = 1'b1;
			return gear_result(gear_base);
		end
		if (b.cpu_ok) begin
			if (fresh_filter) begin
				cpu_filtered = cpu;
				fresh_filter = 1'b0;
			end else begin
				cpu_filtered = (cpu * 25 + cpu_filtered * 75) / 100;
			end
			lvl = alarm_now;
			if (cpu_filtered > cpu_lvl3) lvl = ALARM_THREE;
			else if (cpu_filtered > cpu_lvl2) lvl = ALARM_TWO;
			else if (cpu_filtered > cpu_lvl1) lvl = ALARM_ONE;
			else if (cpu_filtered < cpu_clear) lvl = ALARM_CLEAR;
			else if (cpu_filtered < cpu_lvl1 && alarm_now >= ALARM_TWO) lvl = ALARM_ONE;
			else if (cpu_filtered < cpu_lvl2 && alarm_now >= ALARM_THREE) lvl = ALARM_TWO;
			if (lvl != alarm_now) begin
				// only the cap of the level being left applies
				if (alarm_now == ALARM_THREE && gear_base > GEAR_MAX) gear_base = GEAR_MAX;
				if (alarm_now == ALARM_TWO && lvl < ALARM_TWO && gear_base > CAP_TWO)
					gear_base = CAP_TWO;
				if (alarm_now == ALARM_ONE && lvl == ALARM_CLEAR && gear_base > CAP_ONE)
					gear_base = CAP_ONE;
				hold_left = HOLD_TICKS;
				alarm_now = lvl;
			end
			case (alarm_now)
				ALARM_THREE: gear_floor = MIN_THREE;
				ALARM_TWO:   gear_floor = MIN_TWO;
				ALARM_ONE:   gear_floor = MIN_ONE;
				default:     gear_floor = 0;
			endcase
		end
		if (hold_left > 0) begin
			hold_left--;
		end else if (b.batt_ok) begin
			delta = 0;
			if (batt >= batt_up2) delta = 2;
			else if (batt >= batt_up1) delta = 1;
			else if (batt <= batt_dn2) delta = -2;
			else if (batt <= batt_dn1) delta = -1;
			if (delta != 0) begin
				g = gear_base + delta;
				if (g > GEAR_MAX) g = GEAR_MAX;
				if (g < 0) g = 0;
				gear_base = g;
				hold_left = HOLD_TICKS;
			end
		end
		g = gear_base;
		if (gear_floor > g) g = gear_floor;
		if (g > GEAR_MAX) g = GEAR_MAX;
		return gear_result(g);
	endfunction

	function automatic item_t beat_of(op_t op, int bt, bit bok, int ct, bit cok);
		item_t b;
		b.opcode = op;
		b.batt_temp = bt[TEMP_W-1:0];
		b.batt_ok = bok;
		b.cpu_temp = ct[TEMP_W-1:0];
		b.cpu_ok = cok;
		return b;
	endfunction

	function automatic item_t draw_tick();
		int r;
		int bt;
		int ct;
		op_t op;
		// cpu readings follow a sticky aim so the filter can climb through the levels
		if ($urandom_range(99) < 10) begin
			case ($urandom_range(5))
				0: cpu_aim = cpu_lvl1;
				1: cpu_aim = cpu_lvl2;
				2: cpu_aim = cpu_lvl3;
				3: cpu_aim = cpu_clear;
				4: cpu_aim = 0;
				default: cpu_aim = int'($urandom_range(2047));
			endcase
		end
		if ($urandom_range(99) < 8) ct = int'($urandom_range(2047));
		else ct = cpu_aim + int'($urandom_range(120)) - 60;
		if (ct < 0) ct = 0;
		if (ct > 2047) ct = 2047;
		r = int'($urandom_range(99));
		if (r < 70) begin
			case ($urandom_range(3))
				0: bt = batt_up2;
				1: bt = batt_up1;
				2: bt = batt_dn1;
				default: bt = batt_dn2;
			endcase
			bt = bt + int'($urandom_range(16)) - 8;
		end else if (r < 85) begin
			bt = int'($urandom_range(1400)) - 400;
		end else begin
			bt = int'($urandom_range(2047)) - 1024;
		end
		if (bt < -1024) bt = -1024;
		if (bt > 1023) bt = 1023;
		op = ($urandom_range(99) < 2) ? OP_RESTART : OP_TICK;
		return beat_of(op, bt, $urandom_range(99) < 90, ct, $urandom_range(99) < 88);
	endfunction

	task automatic put_register(input cfg_idx_t idx, input int v);
		logic [TEMP_W-1:0] bits;
		bits = v[TEMP_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bits;
		case (idx)
			REG_BATT_RISE_TWO:   batt_up2 = int'($signed(bits));
			REG_BATT_RISE_ONE:   batt_up1 = int'($signed(bits));
			REG_BATT_FALL_ONE:   batt_dn1 = int'($signed(bits));
			REG_BATT_FALL_TWO:   batt_dn2 = int'($signed(bits));
			REG_CPU_ALARM_ONE:   cpu_lvl1 = int'(bits);
			REG_CPU_ALARM_TWO:   cpu_lvl2 = int'(bits);
			REG_CPU_ALARM_THREE: cpu_lvl3 = int'(bits);
			REG_CPU_ALL_CLEAR:   cpu_clear = int'(bits);
			default: ;
		endcase
	endtask

	task automatic load_thresholds(input int up2, input int up1, input int dn1, input int dn2,
		input int a1, input int a2, input int a3, input int clr);
		put_register(REG_BATT_RISE_TWO, up2);
		put_register(REG_BATT_RISE_ONE, up1);
		put_register(REG_BATT_FALL_ONE, dn1);
		put_register(REG_BATT_FALL_TWO, dn2);
		put_register(REG_CPU_ALARM_ONE, a1);
		put_register(REG_CPU_ALARM_TWO, a2);
		put_register(REG_CPU_ALARM_THREE, a3);
		put_register(REG_CPU_ALL_CLEAR, clr);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		do @(negedge clk);
		while (ticks_waiting.size() != 0 || in_valid || gear_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int k;
		int n;
		ticks_waiting.push_back(beat_of(OP_TICK, 1023, 1, 2047, 1));
		ticks_waiting.push_back(beat_of(OP_RESTART, 1023, 0, 0, 0));
		ticks_waiting.push_back(beat_of(OP_RESTART, -1024, 1, 0, 1));
		ticks_waiting.push_back(beat_of(OP_RESTART, 365, 1, 2047, 1));
		ticks_waiting.push_back(beat_of(OP_RESTART, 449, 1, 700, 0));
		ticks_waiting.push_back(beat_of(OP_RESTART, 1000, 1, 1500, 1));
		ticks_waiting.push_back(beat_of(OP_TICK, 340, 1, 1500, 1));
		// filter decays through every level, capping the base gear on the way down
		for (n = 0; n < 5; n++) ticks_waiting.push_back(beat_of(OP_TICK, 340, 1, 0, 1));
		ticks_waiting.push_back(beat_of(OP_TICK, 340, 1, 2047, 0));
		for (n = 0; n < 4; n++) ticks_waiting.push_back(beat_of(OP_TICK, 1023, 0, 0, 0));
		ticks_waiting.push_back(beat_of(OP_TICK, 1023, 1, 0, 0));
		for (n = 0; n < 5; n++) ticks_waiting.push_back(beat_of(OP_TICK, -1024, 1, 1500, 0));
		ticks_waiting.push_back(beat_of(OP_TICK, 345, 1, 0, 1));
		ticks_waiting.push_back(beat_of(OP_TICK, 330, 1, 1023, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		for (k = 0; k < 7; k++) begin
			case (k)
				1: load_thresholds(400, 380, 300, 250, 600, 800, 1000, 500);
				2: load_thresholds(1000, 1000, -400, -400, 1500, 1500, 1500, 0);
				3: load_thresholds(-400, -400, -400, -400, 0, 0, 0, 0);
				4: load_thresholds(-1024, 1023, -1024, 1023, 2047, 2047, 2047, 2047);
				5: load_thresholds(350, 345, 335, 330, 650, 750, 850, 550);
				6: load_thresholds(int'($urandom_range(1400)) - 400,
					int'($urandom_range(1400)) - 400, int'($urandom_range(1400)) - 400,
					int'($urandom_range(1400)) - 400, int'($urandom_range(1500)),
					int'($urandom_range(1500)), int'($urandom_range(1500)),
					int'($urandom_range(1500)));
				default: ;
			endcase
			for (n = 0; n < PHASE_TICKS; n++) ticks_waiting.push_back(draw_tick());
			settle();
		end

		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin : sender
		item_t nb;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				gear_due.push_back(step_controller(offered));
				beats_taken <= beats_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (ticks_waiting.size() == 0 || (!calm && $urandom_range(99) < 30)) begin
					in_valid <= 1'b0;
				end else begin
					nb = ticks_waiting.pop_front();
					offered <= nb;
					opcode <= nb.opcode;
					batt_temp <= nb.batt_temp;
					batt_ok <= nb.batt_ok;
					cpu_temp <= nb.cpu_temp;
					cpu_ok <= nb.cpu_ok;
					in_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		res_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			// long hold-off so the block backs up into its input
			if (results_seen % 500 == 250) hold_off = 80;
			if (gear_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result beat with none expected, gear %0d", $time, gear);
			end else begin
				want = gear_due.pop_front();
				if (gear !== want.gear || run_mode !== want.lut.run_mode ||
					target_celsius !== want.lut.target_celsius ||
					fixed_fan_rpm !== want.lut.fixed_fan_rpm ||
					chiller_strength !== want.lut.chiller_strength ||
					fan_rpm_ceiling !== want.lut.fan_rpm_ceiling ||
					alarm_level !== want.alarm_level) begin
					failures++;
					if (failures <= 10) begin
						$display("%0t: mismatch: expected gear %0d mode %0d target %0d rpm %0d chill %0d ceiling %0d alarm %0d",
							$time, want.gear, want.lut.run_mode, want.lut.target_celsius,
							want.lut.fixed_fan_rpm, want.lut.chiller_strength,
							want.lut.fan_rpm_ceiling, want.alarm_level);
						$display("%0t: got gear %0d mode %0d target %0d rpm %0d chill %0d ceiling %0d alarm %0d",
							$time, gear, run_mode, target_celsius, fixed_fan_rpm,
							chiller_strength, fan_rpm_ceiling, alarm_level);
					end
				end
			end
		end
		if (hold_off != 0) begin
			out_stall <= 1'b1;
			hold_off--;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 30;
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

@@ cooler_level_thermal_controller.f @@
rtl/core/clt_pkg.sv
rtl/core/clt_step.sv
rtl/core/cooler_level_thermal_controller.sv
bench/tb_top.sv
